>>> hdl/knap_pkg.sv
// Shared constants, item type and helpers for the knapsack best-value block.
package knap_pkg;

  localparam int TABLE_DEPTH     = 256;
  localparam int VALUE_BITS      = 16;
  localparam int ADDR_BITS       = $clog2(TABLE_DEPTH);
  localparam int WEIGHT_BITS     = 8;
  localparam int ITEM_VALUE_BITS = 16;
  localparam int CAP_BITS        = 8;
  localparam int BEST_BITS       = 32;
  localparam int SUM_BITS        = BEST_BITS + 1;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QPTR_BITS       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [ITEM_VALUE_BITS-1:0] VALUE_MASK =
    (VALUE_BITS >= ITEM_VALUE_BITS) ? '1 :
    ITEM_VALUE_BITS'((64'd1 << VALUE_BITS) - 64'd1);

  typedef struct packed {
    logic [WEIGHT_BITS-1:0]     weight;
    logic [ITEM_VALUE_BITS-1:0] value;
    logic                       last;
    logic                       skip;
  } knap_item_t;

  // Read index for the answer, clamped to the last table entry.
  function automatic logic [ADDR_BITS-1:0] cap_index(input logic [CAP_BITS-1:0] cap);
    if (32'(cap) > 32'(TABLE_DEPTH - 1)) begin
      return ADDR_BITS'(TABLE_DEPTH - 1);
    end
    return ADDR_BITS'(cap);
  endfunction

endpackage

>>> hdl/knap_ram.sv
// Generic RAM: one write port, two registered read ports.
module knap_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> hdl/knap_front.sv
// Input side: takes items, flags ones too heavy for the table, queues them.
module knap_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [23:0]            s_axis_tdata,  // item_weight[7:0], item_value[23:8]
  input  logic                   s_axis_tlast,  // last_item
  output logic                   q_valid,
  output knap_pkg::knap_item_t   q_item,
  input  logic                   q_pop
);
  import knap_pkg::*;

  knap_item_t             slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr;
  logic [QPTR_BITS-1:0]   rd_ptr;
  logic [QCNT_BITS-1:0]   count;
  logic                   push;
  knap_item_t             in_item;

  assign s_axis_tready = (count != QCNT_BITS'(QUEUE_DEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid       = (count != '0);
  assign q_item        = slots[rd_ptr];

  always_comb begin
    in_item.weight = s_axis_tdata[WEIGHT_BITS-1:0];
    in_item.value  = s_axis_tdata[WEIGHT_BITS +: ITEM_VALUE_BITS] & VALUE_MASK;
    in_item.last   = s_axis_tlast;
    in_item.skip   = (32'(s_axis_tdata[WEIGHT_BITS-1:0]) >= 32'(TABLE_DEPTH));
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_BITS'(1);
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_BITS'(1);
      end
      if (push && !q_pop) begin
        count <= count + QCNT_BITS'(1);
      end else if (!push && q_pop) begin
        count <= count - QCNT_BITS'(1);
      end
    end
  end

endmodule

>>> hdl/knap_back.sv
// Table engine: walks the best-value table per item and reports the answer.
module knap_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  knap_pkg::knap_item_t        q_item,
  output logic                        q_pop,
  input  logic [knap_pkg::CAP_BITS-1:0] capacity,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [31:0]                 m_axis_tdata   // best_value
);
  import knap_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_WALK  = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_WAIT  = 3'd4;

  logic [2:0]                 state;
  logic [ADDR_BITS-1:0]       cnt;
  logic [ADDR_BITS-1:0]       w_addr;
  logic [ITEM_VALUE_BITS-1:0] val;
  logic                       last;

  logic [TABLE_DEPTH-1:0]     valid_bits;
  logic                       valid_a;
  logic                       valid_b;
  logic                       p1_valid;
  logic [ADDR_BITS-1:0]       p1_addr;

  logic [ADDR_BITS-1:0]       raddr_a;
  logic [ADDR_BITS-1:0]       raddr_b;
  logic [BEST_BITS-1:0]       rdata_a;
  logic [BEST_BITS-1:0]       rdata_b;
  logic [BEST_BITS-1:0]       old_best;
  logic [BEST_BITS-1:0]       base;
  logic [SUM_BITS-1:0]        taken;
  logic [BEST_BITS-1:0]       taken_sat;
  logic [BEST_BITS-1:0]       wdata;

  assign q_pop = (state == ST_IDLE) && q_valid;

  always_comb begin
    raddr_a = cnt;
    raddr_b = cnt - w_addr;
    if (state == ST_READ) begin
      raddr_a = cap_index(capacity);
    end
  end

  knap_ram #(
    .WIDTH (BEST_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (p1_valid),
    .waddr   (p1_addr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  // Entries not written since the last clear read as zero.
  always_comb begin
    old_best  = valid_a ? rdata_a : '0;
    base      = valid_b ? rdata_b : '0;
    taken     = {1'b0, base} + SUM_BITS'(val);
    taken_sat = taken[BEST_BITS] ? '1 : taken[BEST_BITS-1:0];
    wdata     = (taken_sat > old_best) ? taken_sat : old_best;
  end

  always_ff @(posedge clk) begin
    valid_a <= valid_bits[raddr_a];
    valid_b <= valid_bits[raddr_b];
    p1_addr <= cnt;
    if (m_axis_tvalid == 1'b0 && state == ST_WAIT) begin
      m_axis_tdata <= old_best;
    end
    if (q_pop) begin
      w_addr <= ADDR_BITS'(q_item.weight);
      val    <= q_item.value;
      last   <= q_item.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cnt           <= '0;
      valid_bits    <= '0;
      p1_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      p1_valid <= (state == ST_WALK);
      if (p1_valid) begin
        valid_bits[p1_addr] <= 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cnt <= ADDR_BITS'(TABLE_DEPTH - 1);
            if (!q_item.skip) begin
              state <= ST_WALK;
            end else if (q_item.last) begin
              state <= ST_READ;
            end
          end
        end
        ST_WALK: begin
          if (cnt == w_addr) begin
            state <= ST_DRAIN;
          end else begin
            cnt <= cnt - ADDR_BITS'(1);
          end
        end
        ST_DRAIN: begin
          state <= last ? ST_READ : ST_IDLE;
        end
        ST_READ: begin
          if (!m_axis_tvalid) begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          m_axis_tvalid <= 1'b1;
          valid_bits    <= '0;
          state         <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hdl/knapsack_zero_one_best_value.sv
// Top level of the 0/1 knapsack best-value engine.
// Items stream in with weight, value and a last flag; each item is folded into a
// table of best values per capacity (0 to 255), walked from the top entry down
// to the item weight at one entry per cycle through a two-read-port table RAM.
// An item passes the idle, walk and drain states; a result then passes the read
// and wait states once the output register is free. Two items queue ahead of the
// engine. After the last item of a problem the entry at the current capacity
// comes out (sums saturate at all ones) and the table is cleared at once for the
// next problem. Write capacity only while the block is idle; it is not enforced.
module knapsack_zero_one_best_value (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // item_weight[7:0], item_value[23:8]
  input  logic        s_axis_tlast,   // last_item
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // best_value[31:0]
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data        // capacity
);
  import knap_pkg::*;

  logic [CAP_BITS-1:0] capacity;
  logic                q_valid;
  knap_item_t          q_item;
  logic                q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= '0;
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  knap_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  knap_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .capacity      (capacity),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

`ifndef SYNTHESIS
  a_pop_needs_item: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_head_holds: assert property (@(posedge clk) disable iff (rst)
    (q_valid && !q_pop) |=> q_valid)
    else $error("queued item lost without pop");

  a_full_has_head: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> q_valid)
    else $error("input stalled with empty queue");
`endif

endmodule
